// File: design/gemv_pkg.sv
// ----------------------------------------------------------------------------
// gemv_pkg
// Shared widths, command and register codes, item types and controller
// states for the matrix-vector engine.
// ----------------------------------------------------------------------------
package gemv_pkg;

	localparam int MAX_DIM   = 64;
	localparam int DATA_W    = 16;
	localparam int FRAC_BITS = 8;
	localparam int ACC_W     = 56;
	localparam int IDX_W     = $clog2(MAX_DIM);
	localparam int DIM_W     = IDX_W + 1;
	localparam int CFG_IDX_W = 3;
	localparam int CMD_W     = 2;

	localparam logic [CMD_W-1:0] CMD_LOAD_X = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_Y = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MATRIX = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BETA      = 3'd4;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic [IDX_W-1:0]         index;
		logic signed [DATA_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]         y_index;
		logic signed [DATA_W-1:0] y_value;
		logic                     last;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_EMIT,
		ST_FLUSH
	} state_t;

endpackage

// File: design/gemv_matrix_vector_engine.sv
// ----------------------------------------------------------------------------
// gemv_matrix_vector_engine
// y = alpha*op(A)*x + beta*y over a column-major matrix streamed one element
// per item, with x, y and the accumulators held in synchronous memories.
// ----------------------------------------------------------------------------
// Loads of x or y and every matrix element except the final one leave busy
// low, so items may follow back to back. Each element runs through a
// three-stage accumulate pipeline (alpha*a, times x, read-add-write of the
// accumulator memory with forwarding of the previous write). The final element
// of the matrix raises busy while the controller drains the accumulate
// pipeline, reads one accumulator and y entry per cycle over the single read
// port of each memory for len entries, len being num_rows (or num_cols when
// transposed), and then finishes. The updated y entries come out on result, one
// per cycle with done high, in index order, and last marks the final one.
// Results cannot be held off; the receiver must take each one in its cycle.
// ----------------------------------------------------------------------------
module gemv_matrix_vector_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  gemv_pkg::in_item_t                  item,
	output logic                                done,
	output gemv_pkg::out_item_t                 result,
	input  logic                                cfg_wr_en,
	input  logic [gemv_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [gemv_pkg::DATA_W-1:0]         cfg_data
);

	localparam int DW    = gemv_pkg::DATA_W;
	localparam int IW    = gemv_pkg::IDX_W;
	localparam int NW    = gemv_pkg::DIM_W;
	localparam int AW    = gemv_pkg::ACC_W;
	localparam int P1_W  = 2 * DW;
	localparam int P2_W  = 3 * DW;
	localparam int TOT_W = AW + 1;
	localparam int SH    = 3 * gemv_pkg::FRAC_BITS;
	localparam int Q_W   = TOT_W - SH;

	function automatic logic [NW-1:0] dim_clamp(input logic [NW-1:0] v);
		logic [NW-1:0] r;
		if (v == '0) begin
			r = NW'(1);
		end else if (v > NW'(gemv_pkg::MAX_DIM)) begin
			r = NW'(gemv_pkg::MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// configuration
	logic                 transpose_q;
	logic [NW-1:0]        num_rows_q;
	logic [NW-1:0]        num_cols_q;
	logic signed [DW-1:0] alpha_q;
	logic signed [DW-1:0] beta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transpose_q <= 1'b0;
			num_rows_q  <= NW'(gemv_pkg::MAX_DIM);
			num_cols_q  <= NW'(gemv_pkg::MAX_DIM);
			alpha_q     <= DW'(1 << gemv_pkg::FRAC_BITS);
			beta_q      <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				gemv_pkg::REG_TRANSPOSE: transpose_q <= cfg_data[0];
				gemv_pkg::REG_NUM_ROWS:  num_rows_q  <= cfg_data[NW-1:0];
				gemv_pkg::REG_NUM_COLS:  num_cols_q  <= cfg_data[NW-1:0];
				gemv_pkg::REG_ALPHA:     alpha_q     <= cfg_data;
				gemv_pkg::REG_BETA:      beta_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [NW-1:0] rows, cols, len;
	assign rows = dim_clamp(num_rows_q);
	assign cols = dim_clamp(num_cols_q);
	assign len  = transpose_q ? cols : rows;

	// control
	gemv_pkg::state_t state_q, state_nxt;
	logic accept, acc_elem, mat_end;
	logic emit_issue, flush_end;
	logic m_v_s1, m_v_s2;
	logic e_v_s1, e_v_s2;
	logic [IW-1:0] k_q;
	logic k_last;

	assign accept   = start && !busy;
	assign acc_elem = accept && (item.cmd == gemv_pkg::CMD_MATRIX);

	logic [IW-1:0] row_q, col_q;
	logic row_wrap, col_wrap;
	assign row_wrap = ({1'b0, row_q} + NW'(1)) >= rows;
	assign col_wrap = ({1'b0, col_q} + NW'(1)) >= cols;
	assign mat_end  = acc_elem && row_wrap && col_wrap;
	assign k_last   = ({1'b0, k_q} + NW'(1)) == len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (acc_elem) begin
			if (!row_wrap) begin
				row_q <= row_q + IW'(1);
			end else begin
				row_q <= '0;
				col_q <= col_wrap ? '0 : col_q + IW'(1);
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			gemv_pkg::ST_IDLE:  if (mat_end) state_nxt = gemv_pkg::ST_DRAIN;
			gemv_pkg::ST_DRAIN: if (!m_v_s1) state_nxt = gemv_pkg::ST_EMIT;
			gemv_pkg::ST_EMIT:  if (k_last)  state_nxt = gemv_pkg::ST_FLUSH;
			gemv_pkg::ST_FLUSH: if (!e_v_s1) state_nxt = gemv_pkg::ST_IDLE;
			default:            state_nxt = gemv_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy       = (state_q != gemv_pkg::ST_IDLE);
		emit_issue = (state_q == gemv_pkg::ST_EMIT);
		flush_end  = (state_q == gemv_pkg::ST_FLUSH) && !e_v_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gemv_pkg::ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_nxt;
			if (emit_issue) begin
				k_q <= k_last ? '0 : k_q + IW'(1);
			end
		end
	end

	// x store: loads write, matrix elements read
	logic signed [DW-1:0] x_mem [gemv_pkg::MAX_DIM];
	logic signed [DW-1:0] x_rd_q;
	logic [IW-1:0]        x_addr;
	assign x_addr = transpose_q ? row_q : col_q;

	always_ff @(posedge clk) begin
		if (accept && item.cmd == gemv_pkg::CMD_LOAD_X) begin
			x_mem[item.index] <= item.value;
		end
		x_rd_q <= x_mem[x_addr];
	end

	// accumulate stage 1: alpha*a
	logic signed [P1_W-1:0] p1_s1;
	logic [IW-1:0]          a_idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_v_s1 <= 1'b0;
			m_v_s2 <= 1'b0;
		end else begin
			m_v_s1 <= acc_elem;
			m_v_s2 <= m_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		p1_s1    <= alpha_q * item.value;
		a_idx_s1 <= transpose_q ? col_q : row_q;
	end

	// accumulate stage 2: times x
	logic signed [P2_W-1:0] prod_s2;
	logic [IW-1:0]          a_idx_s2;

	always_ff @(posedge clk) begin
		prod_s2  <= p1_s1 * x_rd_q;
		a_idx_s2 <= a_idx_s1;
	end

	// accumulator store with one valid bit per entry
	logic signed [AW-1:0] acc_mem [gemv_pkg::MAX_DIM];
	logic signed [AW-1:0] acc_rd_q;
	logic [IW-1:0]        acc_raddr;
	logic [gemv_pkg::MAX_DIM-1:0] acc_vld_q;
	logic                 fwd_v_q;
	logic [IW-1:0]        fwd_idx_q;
	logic signed [AW-1:0] fwd_data_q;
	logic signed [AW-1:0] acc_base, acc_sum;

	assign acc_raddr = emit_issue ? k_q : a_idx_s1;

	// the write of the previous element is not yet visible in the read data
	always_comb begin
		if (fwd_v_q && fwd_idx_q == a_idx_s2) begin
			acc_base = fwd_data_q;
		end else if (acc_vld_q[a_idx_s2]) begin
			acc_base = acc_rd_q;
		end else begin
			acc_base = '0;
		end
		acc_sum = acc_base + AW'(prod_s2);
	end

	always_ff @(posedge clk) begin
		if (m_v_s2) begin
			acc_mem[a_idx_s2] <= acc_sum;
		end
		acc_rd_q   <= acc_mem[acc_raddr];
		fwd_idx_q  <= a_idx_s2;
		fwd_data_q <= acc_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_q <= '0;
			fwd_v_q   <= 1'b0;
		end else begin
			fwd_v_q <= m_v_s2;
			if (flush_end) begin
				acc_vld_q <= '0;
			end else if (m_v_s2) begin
				acc_vld_q[a_idx_s2] <= 1'b1;
			end
		end
	end

	// emission pipeline
	logic [IW-1:0]          e_idx_s1, e_idx_s2;
	logic                   e_last_s1, e_last_s2;
	logic signed [P1_W-1:0] by_s2;
	logic signed [AW-1:0]   acc_s2;
	logic signed [DW-1:0]   y_rd_q;
	logic signed [DW-1:0]   y_mem [gemv_pkg::MAX_DIM];
	logic signed [TOT_W-1:0] total;
	logic signed [Q_W-1:0]  q;
	logic signed [DW-1:0]   y_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_v_s1 <= 1'b0;
			e_v_s2 <= 1'b0;
			done   <= 1'b0;
		end else begin
			e_v_s1 <= emit_issue;
			e_v_s2 <= e_v_s1;
			done   <= e_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		e_idx_s1  <= k_q;
		e_last_s1 <= k_last;
		e_idx_s2  <= e_idx_s1;
		e_last_s2 <= e_last_s1;
		by_s2     <= beta_q * y_rd_q;
		acc_s2    <= acc_vld_q[e_idx_s1] ? acc_rd_q : '0;
	end

	always_comb begin
		total = (TOT_W'(by_s2) <<< gemv_pkg::FRAC_BITS) + TOT_W'(acc_s2);
		q     = total[TOT_W-1:SH];
		// clamp when the bits above the result do not all match its sign
		if (q[Q_W-1:DW-1] == '0 || q[Q_W-1:DW-1] == '1) begin
			y_sat = q[DW-1:0];
		end else if (q[Q_W-1]) begin
			y_sat = {1'b1, {(DW-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(DW-1){1'b1}}};
		end
	end

	// y store: loads and write-back of results share the write port
	always_ff @(posedge clk) begin
		if (e_v_s2) begin
			y_mem[e_idx_s2] <= y_sat;
		end else if (accept && item.cmd == gemv_pkg::CMD_LOAD_Y) begin
			y_mem[item.index] <= item.value;
		end
		y_rd_q <= y_mem[k_q];
	end

	always_ff @(posedge clk) begin
		if (e_v_s2) begin
			result.y_index <= e_idx_s2;
			result.y_value <= y_sat;
			result.last    <= e_last_s2;
		end
	end

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the matrix-vector engine. Loads x and y, streams
// column-major matrices under many register settings (clamped and extreme
// sizes, transpose, saturating scales, settings changed mid-matrix), and
// checks every emitted y item against a cycle-free model of the datapath.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [gemv_pkg::CMD_W-1:0]     CMD_NONE   = 2'd3;
	localparam logic [gemv_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int                             N_ITEMS    = 300;
	localparam int                             SETTLE     = 8;
	localparam longint Y_MAX = (64'sd1 <<< (gemv_pkg::DATA_W - 1)) - 1;
	localparam longint Y_MIN = -Y_MAX - 1;

	class gemv_tracker;
		logic                               transpose;
		logic [gemv_pkg::DIM_W-1:0]         num_rows;
		logic [gemv_pkg::DIM_W-1:0]         num_cols;
		logic signed [gemv_pkg::DATA_W-1:0] alpha;
		logic signed [gemv_pkg::DATA_W-1:0] beta;
		logic signed [gemv_pkg::DATA_W-1:0] x_mem [gemv_pkg::MAX_DIM];
		logic signed [gemv_pkg::DATA_W-1:0] y_mem [gemv_pkg::MAX_DIM];
		bit                                 x_set [gemv_pkg::MAX_DIM];
		bit                                 y_set [gemv_pkg::MAX_DIM];
		logic signed [gemv_pkg::ACC_W-1:0]  acc [gemv_pkg::MAX_DIM];
		int                                 row_cnt;
		int                                 col_cnt;
		gemv_pkg::out_item_t                y_expected [$];
		int                                 mismatches;

		function new();
			transpose  = 1'b0;
			num_rows   = 7'd64;
			num_cols   = 7'd64;
			alpha      = 16'sd256;
			beta       = 16'sd0;
			row_cnt    = 0;
			col_cnt    = 0;
			mismatches = 0;
			foreach (acc[i]) begin
				acc[i]   = '0;
				x_set[i] = 1'b0;
				y_set[i] = 1'b0;
			end
		endfunction

		function int dim(logic [gemv_pkg::DIM_W-1:0] v);
			if (v == 0)
				return 1;
			if (v > gemv_pkg::MAX_DIM)
				return gemv_pkg::MAX_DIM;
			return int'(v);
		endfunction

		function void set_reg(logic [gemv_pkg::CFG_IDX_W-1:0] idx,
				logic [gemv_pkg::DATA_W-1:0] data);
			case (idx)
				gemv_pkg::REG_TRANSPOSE: transpose = data[0];
				gemv_pkg::REG_NUM_ROWS:  num_rows  = data[gemv_pkg::DIM_W-1:0];
				gemv_pkg::REG_NUM_COLS:  num_cols  = data[gemv_pkg::DIM_W-1:0];
				gemv_pkg::REG_ALPHA:     alpha     = data;
				gemv_pkg::REG_BETA:      beta      = data;
				default: ;
			endcase
		endfunction

		// x entry that the next matrix element reads
		function int x_pos();
			return transpose ? row_cnt : col_cnt;
		endfunction

		function int out_len();
			return transpose ? dim(num_cols) : dim(num_rows);
		endfunction

		function bit closes_matrix();
			return (row_cnt + 1 >= dim(num_rows)) && (col_cnt + 1 >= dim(num_cols));
		endfunction

		function void take_item(gemv_pkg::in_item_t it);
			int                                 rows;
			int                                 cols;
			int                                 r;
			int                                 c;
			int                                 ai;
			int                                 len;
			longint                             prod;
			longint                             by;
			longint                             tot;
			longint                             q;
			logic signed [gemv_pkg::DATA_W-1:0] xs;
			logic signed [gemv_pkg::DATA_W-1:0] res;
			case (it.cmd)
				gemv_pkg::CMD_LOAD_X: begin
					x_mem[it.index] = it.value;
					x_set[it.index] = 1'b1;
				end
				gemv_pkg::CMD_LOAD_Y: begin
					y_mem[it.index] = it.value;
					y_set[it.index] = 1'b1;
				end
				gemv_pkg::CMD_MATRIX: begin
					rows = dim(num_rows);
					cols = dim(num_cols);
					r    = row_cnt;
					c    = col_cnt;
					ai   = transpose ? c : r;
					xs   = transpose ? x_mem[r] : x_mem[c];
					prod = longint'(alpha) * longint'($signed(it.value)) * longint'(xs);
					acc[ai] = acc[ai] + prod[gemv_pkg::ACC_W-1:0];
					if (r + 1 < rows) begin
						row_cnt = r + 1;
					end else begin
						row_cnt = 0;
						if (c + 1 < cols) begin
							col_cnt = c + 1;
						end else begin
							col_cnt = 0;
							len = transpose ? cols : rows;
							for (int k = 0; k < len; k++) begin
								by  = longint'(beta) * longint'(y_mem[k]);
								tot = (by <<< gemv_pkg::FRAC_BITS) + longint'(acc[k]);
								q   = tot >>> (3 * gemv_pkg::FRAC_BITS);
								if (q > Y_MAX)
									q = Y_MAX;
								else if (q < Y_MIN)
									q = Y_MIN;
								res      = q[gemv_pkg::DATA_W-1:0];
								y_mem[k] = res;
								y_expected.push_back('{y_index: gemv_pkg::IDX_W'(k),
									y_value: res, last: (k == len - 1)});
							end
							foreach (acc[i])
								acc[i] = '0;
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void check_y(gemv_pkg::out_item_t got);
			gemv_pkg::out_item_t want;
			if (y_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected y item: idx %0d value %0d last %0b",
						got.y_index, got.y_value, got.last);
				return;
			end
			want = y_expected.pop_front();
			if (got.y_index !== want.y_index || got.y_value !== want.y_value ||
					got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("y mismatch: expected idx %0d value %0d last %0b,",
						want.y_index, want.y_value, want.last,
						" got idx %0d value %0d last %0b",
						got.y_index, got.y_value, got.last);
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	gemv_pkg::in_item_t             item;
	logic                           done;
	gemv_pkg::out_item_t            result;
	logic                           cfg_wr_en;
	logic [gemv_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [gemv_pkg::DATA_W-1:0]    cfg_data;

	gemv_tracker sb = new();
	int          n_items = 0;
	bit          no_gaps = 1'b0;

	gemv_matrix_vector_engine i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			sb.check_y(result);
	end

	function automatic gemv_pkg::in_item_t pack_item(logic [gemv_pkg::CMD_W-1:0] c, int i,
			logic [gemv_pkg::DATA_W-1:0] v);
		return '{cmd: c, index: gemv_pkg::IDX_W'(i), value: v};
	endfunction

	function automatic logic [gemv_pkg::DATA_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0:       return 16'h7fff;
			1:       return 16'h8000;
			2:       return 16'h0000;
			3, 4, 5: return 16'($urandom_range(0, 1023) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [gemv_pkg::DIM_W-1:0] small_dim();
		if ($urandom_range(0, 9) == 0)
			return 7'd0;
		return 7'($urandom_range(1, 6));
	endfunction

	task automatic send(input gemv_pkg::in_item_t it);
		int gap;
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy !== 1'b0);
		sb.take_item(it);
		if (it.cmd != CMD_NONE)
			n_items++;
		gap = no_gaps ? 0 : gap_len();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// load any x or y entry the element would read before it was written
	task automatic send_element(input logic [gemv_pkg::DATA_W-1:0] v);
		if (!sb.x_set[sb.x_pos()])
			send(pack_item(gemv_pkg::CMD_LOAD_X, sb.x_pos(), rand_value()));
		if (sb.closes_matrix()) begin
			for (int k = 0; k < sb.out_len(); k++)
				if (!sb.y_set[k])
					send(pack_item(gemv_pkg::CMD_LOAD_Y, k, rand_value()));
		end
		send(pack_item(gemv_pkg::CMD_MATRIX, $urandom_range(0, gemv_pkg::MAX_DIM - 1), v));
	endtask

	task automatic send_noise();
		case ($urandom_range(0, 2))
			0: send(pack_item(gemv_pkg::CMD_LOAD_X,
				$urandom_range(0, gemv_pkg::MAX_DIM - 1), rand_value()));
			1: send(pack_item(gemv_pkg::CMD_LOAD_Y,
				$urandom_range(0, gemv_pkg::MAX_DIM - 1), rand_value()));
			default: send(pack_item(CMD_NONE,
				$urandom_range(0, gemv_pkg::MAX_DIM - 1), 16'($urandom)));
		endcase
	endtask

	task automatic finish_matrix(input int noise_pct);
		bit closing;
		do begin
			if ($urandom_range(0, 99) < noise_pct)
				send_noise();
			closing = sb.closes_matrix();
			send_element(rand_value());
		end while (!closing);
	endtask

	// hold the sender until every pending y item is out, then let the pipe settle
	task automatic wait_results();
		start <= 1'b0;
		while (sb.y_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [gemv_pkg::CFG_IDX_W-1:0] idx,
			input logic [gemv_pkg::DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_idx   <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_config();
		logic [gemv_pkg::DIM_W-1:0] big;
		logic [gemv_pkg::DIM_W-1:0] tiny;
		big  = $urandom_range(0, 1) ? 7'd64 : 7'($urandom_range(65, 127));
		tiny = 7'($urandom_range(0, 1));
		write_reg(gemv_pkg::REG_TRANSPOSE, 16'($urandom_range(0, 1)));
		if ($urandom_range(0, 9) == 0) begin
			// one dimension at its maximum, the other minimal
			if ($urandom_range(0, 1)) begin
				write_reg(gemv_pkg::REG_NUM_ROWS, 16'(big));
				write_reg(gemv_pkg::REG_NUM_COLS, 16'(tiny));
			end else begin
				write_reg(gemv_pkg::REG_NUM_ROWS, 16'(tiny));
				write_reg(gemv_pkg::REG_NUM_COLS, 16'(big));
			end
		end else begin
			write_reg(gemv_pkg::REG_NUM_ROWS, 16'(small_dim()));
			write_reg(gemv_pkg::REG_NUM_COLS, 16'(small_dim()));
		end
		if ($urandom_range(0, 1))
			write_reg(gemv_pkg::REG_ALPHA, rand_value());
		if ($urandom_range(0, 1))
			write_reg(gemv_pkg::REG_BETA, rand_value());
	endtask

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		item      <= '0;
		cfg_wr_en <= 1'b0;
		cfg_idx   <= '0;
		cfg_data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 2x2 with full-scale data at unit alpha and beta; the results stay in range
		write_reg(gemv_pkg::REG_TRANSPOSE, 16'd0);
		write_reg(gemv_pkg::REG_NUM_ROWS, 16'd2);
		write_reg(gemv_pkg::REG_NUM_COLS, 16'd2);
		write_reg(gemv_pkg::REG_ALPHA, 16'h0100);
		write_reg(gemv_pkg::REG_BETA, 16'h0100);
		write_reg(REG_UNUSED, 16'hffff);
		send(pack_item(gemv_pkg::CMD_LOAD_X, 0, 16'h7fff));
		send(pack_item(gemv_pkg::CMD_LOAD_X, 1, 16'h8000));
		send(pack_item(gemv_pkg::CMD_LOAD_Y, 0, 16'h8000));
		send(pack_item(gemv_pkg::CMD_LOAD_Y, 1, 16'h7fff));
		send(pack_item(gemv_pkg::CMD_LOAD_X, 63, 16'h5a5a));
		send(pack_item(gemv_pkg::CMD_LOAD_Y, 63, 16'ha5a5));
		send(pack_item(CMD_NONE, 42, 16'h1234));
		send_element(16'h7fff);
		send_element(16'h8000);
		send_element(16'h0000);
		send_element(16'h0100);
		wait_results();

		// settings changed part way through a matrix, x loaded mid-stream
		write_reg(gemv_pkg::REG_NUM_ROWS, 16'd3);
		write_reg(gemv_pkg::REG_NUM_COLS, 16'd3);
		write_reg(gemv_pkg::REG_BETA, 16'h0080);
		repeat (4) send_element(rand_value());
		send(pack_item(gemv_pkg::CMD_LOAD_X, 2, 16'h0180));
		wait_results();
		write_reg(gemv_pkg::REG_TRANSPOSE, 16'd1);
		write_reg(gemv_pkg::REG_NUM_ROWS, 16'd1);
		finish_matrix(0);
		wait_results();

		// clamped dimensions at both ends, extreme scales
		write_reg(gemv_pkg::REG_TRANSPOSE, 16'd0);
		write_reg(gemv_pkg::REG_NUM_ROWS, 16'd127);
		write_reg(gemv_pkg::REG_NUM_COLS, 16'd0);
		write_reg(gemv_pkg::REG_ALPHA, 16'h8000);
		write_reg(gemv_pkg::REG_BETA, 16'h7fff);
		finish_matrix(0);
		wait_results();
		write_reg(gemv_pkg::REG_TRANSPOSE, 16'd1);
		write_reg(gemv_pkg::REG_NUM_ROWS, 16'd1);
		write_reg(gemv_pkg::REG_NUM_COLS, 16'd64);
		write_reg(gemv_pkg::REG_ALPHA, 16'h7fff);
		write_reg(gemv_pkg::REG_BETA, 16'h8000);
		no_gaps = 1'b1;
		finish_matrix(0);
		no_gaps = 1'b0;
		wait_results();

		while (n_items < N_ITEMS) begin
			wait_results();
			random_config();
			no_gaps = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0:       repeat (5) send_noise();
				1:       repeat ($urandom_range(1, 3)) send_element(rand_value());
				default: finish_matrix(15);
			endcase
		end
		wait_results();

		if (sb.mismatches == 0 && sb.y_expected.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
